/* design/swm_pkg.sv */
// Shared types and constants for the sliding window median filter.
package swm_pkg;

	localparam int unsigned SAMPLE_W    = 32;
	localparam int unsigned SIZE_W      = 7;
	localparam int unsigned DEF_MAX_WIN = 64;
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic step;
		logic full;
	} swm_ctl_t;

endpackage

/* design/swm_cell.sv */
// One sorted-window cell: holds a sample and its age, updates from its neighbors.
module swm_cell #(
	parameter int unsigned AW    = 6,
	parameter bit          FIRST = 1'b0
) (
	input  logic                clk,
	input  swm_pkg::swm_ctl_t   ctl,
	input  swm_pkg::sample_t    sample,
	input  logic [AW-1:0]       oldest_age,
	input  logic                valid,
	input  logic                rm_here,
	input  logic                rm_below,
	input  swm_pkg::sample_t    dn_val,
	input  logic [AW-1:0]       dn_age,
	input  logic                dn_gt,
	input  swm_pkg::sample_t    up_val,
	input  logic [AW-1:0]       up_age,
	input  logic                up_gt,
	output swm_pkg::sample_t    val,
	output logic [AW-1:0]       age,
	output logic                gt,
	output logic                rm
);
	import swm_pkg::*;

	sample_t       val_q;
	logic [AW-1:0] age_q;
	sample_t       s_val;
	logic [AW-1:0] s_age;
	logic          s_gt;
	sample_t       m_val;
	logic [AW-1:0] m_age;
	logic          m_gt;

	assign gt  = !valid || (val_q > sample);
	assign rm  = ctl.full && valid && (age_q == oldest_age);
	assign val = val_q;
	assign age = age_q;

	// s, m: list with the oldest removed, at this rank (s) and one below (m)
	always_comb begin
		s_val = rm_here ? up_val : val_q;
		s_age = rm_here ? up_age : age_q;
		s_gt  = rm_here ? up_gt : gt;
		m_val = rm_below ? val_q : dn_val;
		m_age = rm_below ? age_q : dn_age;
		m_gt  = rm_below ? gt : dn_gt;
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (!s_gt) begin
				val_q <= s_val;
				age_q <= s_age + AW'(1);
			end else if (FIRST || !m_gt) begin
				val_q <= sample;
				age_q <= '0;
			end else begin
				val_q <= m_val;
				age_q <= m_age + AW'(1);
			end
		end
	end

endmodule

/* design/sliding_window_median.sv */
// Sliding window median filter: top level with the sorted cell chain and output register.
// Each cell compares against the new sample in parallel as the chain updates.
// Throughput: one sample per cycle while no median is blocked at the output.
// The median register is fed from the cell chain through a rank mux once out_free.
// Reset: arst_n clears the fill count, pending and output flags; window size returns to 3.
// Cell contents are not reset; only entries below the fill count are ever used.
module sliding_window_median #(
	parameter int unsigned MAX_WINDOW = swm_pkg::DEF_MAX_WIN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [swm_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [31:0] sample
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [swm_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // [31:0] median
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [swm_pkg::SIZE_W-1:0]    cfg_data
);
	import swm_pkg::*;

	localparam int unsigned N  = MAX_WINDOW;
	localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;
	localparam int unsigned KW = $clog2(N + 1);

	logic [SIZE_W-1:0] wsize_q;
	logic [KW-1:0]     fill_q;
	logic              pend_q;
	logic              out_valid_q;
	sample_t           out_data_q;

	logic [KW-1:0]     k_eff;
	logic [AW-1:0]     oldest_age;
	logic [AW-1:0]     mid_idx;
	swm_ctl_t          ctl;
	sample_t           sample;
	logic              out_free;
	logic              yields;

	sample_t           cval [N];
	logic [AW-1:0]     cage [N];
	logic [N-1:0]      cgt;
	logic [N-1:0]      crm;
	logic [N-1:0]      rpre;

	always_comb begin
		if (wsize_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(wsize_q) > 32'(N)) begin
			k_eff = KW'(N);
		end else begin
			k_eff = KW'(wsize_q);
		end
	end

	assign oldest_age    = AW'(k_eff - KW'(1));
	assign mid_idx       = AW'((k_eff - KW'(1)) >> 1);
	assign sample        = s_axis_tdata;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !pend_q || out_free;
	assign cfg_ready     = 1'b1;
	assign ctl.step      = s_axis_tvalid && s_axis_tready;
	assign ctl.full      = (fill_q == k_eff);
	assign yields        = ctl.full || (fill_q + KW'(1) == k_eff);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// rank of the removed entry as a thermometer
	always_comb begin
		for (int i = 0; i < N; i++) begin
			rpre[i] = |(crm & ((N'(1) << i) | ((N'(1) << i) - N'(1))));
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		sample_t       dv, uv;
		logic [AW-1:0] da, ua;
		logic          dg, ug, rb;

		if (i == 0) begin : g_lo
			assign dv = '0;
			assign da = '0;
			assign dg = 1'b1;
			assign rb = 1'b0;
		end else begin : g_mid
			assign dv = cval[i-1];
			assign da = cage[i-1];
			assign dg = cgt[i-1];
			assign rb = rpre[i-1];
		end
		if (i == N - 1) begin : g_hi
			assign uv = '0;
			assign ua = '0;
			assign ug = 1'b1;
		end else begin : g_up
			assign uv = cval[i+1];
			assign ua = cage[i+1];
			assign ug = cgt[i+1];
		end

		swm_cell #(.AW(AW), .FIRST(i == 0)) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.sample     (sample),
			.oldest_age (oldest_age),
			.valid      (KW'(i) < fill_q),
			.rm_here    (rpre[i]),
			.rm_below   (rb),
			.dn_val     (dv),
			.dn_age     (da),
			.dn_gt      (dg),
			.up_val     (uv),
			.up_age     (ua),
			.up_gt      (ug),
			.val        (cval[i]),
			.age        (cage[i]),
			.gt         (cgt[i]),
			.rm         (crm[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q     <= SIZE_RESET;
			fill_q      <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				wsize_q <= cfg_data;
				fill_q  <= '0;
			end else if (ctl.step && !ctl.full) begin
				fill_q <= fill_q + KW'(1);
			end
			if (pend_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (ctl.step) begin
				pend_q <= yields;
			end else if (out_free) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q && out_free) begin
			out_data_q <= cval[mid_idx];
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k_eff)
		else $error("fill count above window size");
	a_one_removed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(crm))
		else $error("more than one cell marked oldest");
	a_full_removes: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && ctl.full |-> $onehot(crm))
		else $error("full window without an oldest cell");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q && !out_free |-> !s_axis_tready)
		else $error("item accepted while a median is blocked");
	a_cfg_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> fill_q == '0)
		else $error("window not emptied by size write");
`endif

endmodule

/* verif/tb.sv */
// Self-checking testbench for the sliding window median filter.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swm_pkg::*;

	localparam int MAX_WIN      = 64;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 1800;

	localparam sample_t S_MIN  = sample_t'(32'h8000_0000);
	localparam sample_t S_MAX  = sample_t'(32'h7FFF_FFFF);
	localparam sample_t S_ZERO = sample_t'(0);
	localparam sample_t S_ONES = sample_t'(32'hFFFF_FFFF);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [SAMPLE_W-1:0] s_axis_tdata = '0;   // [31:0] sample
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [SAMPLE_W-1:0] m_axis_tdata;        // [31:0] median
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SIZE_W-1:0] cfg_data = '0;

	sample_t window_fifo[$];
	sample_t expected_medians[$];
	int win_k = 3;
	int errors = 0;
	int cycle_count = 0;
	int samples_sent = 0;
	int sink_hold = 0;
	bit src_burst = 1'b0;
	bit sink_burst = 1'b0;

	sliding_window_median u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// lower median: the entry with at most rank entries below it and more than rank entries not above it, ties included
	function automatic sample_t window_lower_median();
		int rank;
		int below;
		int not_above;
		sample_t pick;
		rank = (window_fifo.size() - 1) / 2;
		pick = window_fifo[0];
		foreach (window_fifo[i]) begin
			below = 0;
			not_above = 0;
			foreach (window_fifo[j]) begin
				if (window_fifo[j] < window_fifo[i])
					below++;
				if (window_fifo[j] <= window_fifo[i])
					not_above++;
			end
			if (below <= rank && rank < not_above)
				pick = window_fifo[i];
		end
		return pick;
	endfunction

	function automatic void track_sample(input sample_t s);
		if (window_fifo.size() >= win_k)
			void'(window_fifo.pop_front());
		window_fifo.push_back(s);
		if (window_fifo.size() == win_k)
			expected_medians.push_back(window_lower_median());
	endfunction

	function automatic sample_t pick_sample();
		sample_t s;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: s = S_MIN;
					1: s = S_MAX;
					2: s = S_ZERO;
					default: s = S_ONES;
				endcase
			end
			1, 2, 3: s = sample_t'($urandom_range(0, 8)) - sample_t'(4);
			default: s = sample_t'($urandom);
		endcase
		return s;
	endfunction

	task automatic send_sample(input sample_t s);
		int gap;
		gap = src_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= s;
		do @(posedge clk); while (!s_axis_tready);
		track_sample(s);
		samples_sent++;
	endtask

	// items during the fill give no median, so allow the pipeline to empty
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_medians.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window_size(input int value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= SIZE_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_k = value & 7'h7F;
		if (win_k < 1)
			win_k = 1;
		if (win_k > MAX_WIN)
			win_k = MAX_WIN;
		window_fifo.delete();
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_medians.size() == 0) begin
				$display("%t unexpected median: expected none, got %0d", $realtime,
					sample_t'(m_axis_tdata));
				errors++;
			end else begin
				if (sample_t'(m_axis_tdata) !== expected_medians[0]) begin
					$display("%t median mismatch: expected %0d, got %0d", $realtime,
						expected_medians[0], sample_t'(m_axis_tdata));
					errors++;
				end
				void'(expected_medians.pop_front());
			end
		end
	end

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				sink_burst = !sink_burst;
			stall = sink_burst ? 0 : $urandom_range(0, 5);
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic test_reset_size();
		send_sample(S_MIN);
		send_sample(S_MAX);
		send_sample(S_ZERO);
		send_sample(S_ONES);
		send_sample(sample_t'(1));
		send_sample(sample_t'(32'h5555_5555));
		send_sample(sample_t'(32'hAAAA_AAAA));
		send_sample(sample_t'(5));
		send_sample(sample_t'(5));
		send_sample(sample_t'(5));
	endtask

	task automatic test_size_zero();
		write_window_size(0);
		send_sample(S_MAX);
		send_sample(S_MIN);
		send_sample(sample_t'(-7));
	endtask

	task automatic test_even_window();
		write_window_size(2);
		send_sample(sample_t'(9));
		send_sample(sample_t'(-9));
		send_sample(sample_t'(9));
		send_sample(sample_t'(9));
	endtask

	task automatic test_partial_rewrite();
		write_window_size(4);
		send_sample(sample_t'(100));
		send_sample(sample_t'(-100));
		write_window_size(3);
		send_sample(sample_t'(2));
		send_sample(sample_t'(1));
		send_sample(sample_t'(3));
		send_sample(sample_t'(1));
	endtask

	task automatic test_random_sizes();
		int fixed_sizes[$] = '{1, 64, 127, 65, 2, 3, 0};
		int size;
		int eff;
		int count;
		while (samples_sent < RANDOM_ITEMS) begin
			if (fixed_sizes.size() != 0)
				size = fixed_sizes.pop_front();
			else if ($urandom_range(0, 9) == 0)
				size = $urandom_range(13, 127);
			else
				size = $urandom_range(1, 12);
			write_window_size(size);
			eff = win_k;
			count = eff + $urandom_range(10, 120);
			repeat (count) begin
				if ($urandom_range(0, 49) == 0)
					src_burst = !src_burst;
				send_sample(pick_sample());
			end
		end
		src_burst = 1'b0;
	endtask

	task automatic test_output_backpressure();
		write_window_size(5);
		src_burst = 1'b1;
		sink_hold = 200;
		repeat (60) send_sample(pick_sample());
		src_burst = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_size();
		test_size_zero();
		test_even_window();
		test_partial_rewrite();
		test_output_backpressure();
		test_random_sizes();
		wait_idle();
		if (expected_medians.size() != 0) begin
			$display("%t %0d medians never arrived", $realtime, expected_medians.size());
			errors++;
		end
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
